// File: design/lphs_pkg.sv
// Shared types and constants for the linear probing hash set.
package lphs_pkg;

  localparam int HASH_W      = 32;
  localparam int IN_KEY_W    = 32;
  localparam int CAP_W       = 9;
  localparam int SLOT_W      = 8;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;
  localparam int MOD_BITS    = 4;
  localparam int MOD_STEPS   = HASH_W / MOD_BITS;
  localparam int MOD_STEP_W  = $clog2(MOD_STEPS);

  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;
  localparam logic [CAP_W-1:0] CAP_MIN   = 9'd2;
  localparam int               CAP_LIMIT = (1 << CAP_W) - 1;

  localparam logic [PADDR_W-3:0] CFG_IDX_CAPACITY = 1'b0;

  localparam logic [1:0] OP_ADD      = 2'd0;
  localparam logic [1:0] OP_REMOVE   = 2'd1;
  localparam logic [1:0] OP_CONTAINS = 2'd2;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [1:0] STAT_FULL      = 2'd2;

  typedef struct packed {
    logic [1:0]          op;
    logic [IN_KEY_W-1:0] key;
    logic [HASH_W-1:0]   key_hash;
  } in_item_t;

  typedef struct packed {
    logic [1:0]          status;
    logic                found;
    logic [SLOT_W-1:0]   slot;
    logic [IN_KEY_W-1:0] removed_key;
    logic [CAP_W-1:0]    entry_total;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_PROBE,
    ST_OUT
  } state_t;

endpackage

// File: design/lphs_cfg_regs.sv
// Configuration register file holding the capacity and its clamped value.
module lphs_cfg_regs #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lphs_pkg::PADDR_W-1:0]  paddr,
  input  logic [lphs_pkg::PDATA_W-1:0]  pwdata,
  output logic [lphs_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output logic [lphs_pkg::CAP_W-1:0]    eff_cap
);
  import lphs_pkg::*;

  localparam logic [CAP_W-1:0] CAP_MAX =
    CAP_W'((TABLE_DEPTH < CAP_LIMIT) ? TABLE_DEPTH : CAP_LIMIT);

  logic [CAP_W-1:0] capacity_r;
  logic [CAP_W-1:0] capacity_nxt;
  logic             reg_hit;

  assign reg_hit = (paddr[PADDR_W-1:2] == CFG_IDX_CAPACITY);
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? PDATA_W'(capacity_r) : '0;

  always_comb begin
    capacity_nxt = capacity_r;
    if (psel && penable && pwrite && reg_hit) begin
      capacity_nxt = pwdata[CAP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_RESET;
    end else begin
      capacity_r <= capacity_nxt;
    end
  end

  always_comb begin
    if (capacity_r < CAP_MIN) begin
      eff_cap = CAP_MIN;
    end else if (capacity_r > CAP_MAX) begin
      eff_cap = CAP_MAX;
    end else begin
      eff_cap = capacity_r;
    end
  end

endmodule

// File: design/lphs_mod_unit.sv
// Iterative hash modulo capacity, four dividend bits per cycle.
module lphs_mod_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [lphs_pkg::HASH_W-1:0]  dividend,
  input  logic [lphs_pkg::CAP_W-1:0]   divisor,
  output logic                         done,
  output logic [lphs_pkg::CAP_W-1:0]   remainder
);
  import lphs_pkg::*;

  localparam logic [MOD_STEP_W-1:0] STEP_LAST = MOD_STEP_W'(MOD_STEPS - 1);

  logic                  busy_r;
  logic                  done_r;
  logic [MOD_STEP_W-1:0] step_r;
  logic [HASH_W-1:0]     quo_r;
  logic [CAP_W-1:0]      div_r;
  logic [CAP_W-1:0]      rem_r;
  logic [CAP_W-1:0]      rem_nxt;
  logic [HASH_W-1:0]     quo_nxt;

  always_comb begin
    logic [CAP_W:0]   part;
    logic [CAP_W-1:0] r;
    r = rem_r;
    part = '0;
    for (int i = 0; i < MOD_BITS; i++) begin
      part = {r, quo_r[HASH_W-1-i]};
      if (part >= {1'b0, div_r}) begin
        part = part - {1'b0, div_r};
      end
      r = part[CAP_W-1:0];
    end
    rem_nxt = r;
    quo_nxt = quo_r << MOD_BITS;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= busy_r && !start && (step_r == STEP_LAST);
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + MOD_STEP_W'(1);
        if (step_r == STEP_LAST) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      div_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

// File: design/lphs_slot_mem.sv
// Slot valid and key memories with a clearing sweep of the valid bits after reset.
module lphs_slot_mem #(
  parameter int TABLE_DEPTH = 256,
  parameter int KEY_WIDTH   = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [$clog2(TABLE_DEPTH)-1:0] rd_addr,
  output logic                           rd_vld,
  output logic [KEY_WIDTH-1:0]           rd_key,
  input  logic [$clog2(TABLE_DEPTH)-1:0] wr_addr,
  input  logic                           vld_wr_en,
  input  logic                           wr_vld,
  input  logic                           key_wr_en,
  input  logic [KEY_WIDTH-1:0]           wr_key,
  output logic                           ready
);
  import lphs_pkg::*;

  localparam int             IDX_W    = $clog2(TABLE_DEPTH);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_DEPTH - 1);

  logic                 vld_mem [TABLE_DEPTH];
  logic [KEY_WIDTH-1:0] key_mem [TABLE_DEPTH];

  logic             clearing_r;
  logic [IDX_W-1:0] clr_cnt_r;
  logic             vld_we;
  logic [IDX_W-1:0] vld_waddr;
  logic             vld_wdata;

  assign vld_we    = clearing_r || vld_wr_en;
  assign vld_waddr = clearing_r ? clr_cnt_r : wr_addr;
  assign vld_wdata = clearing_r ? 1'b0 : wr_vld;
  assign ready     = !clearing_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clearing_r) begin
      clr_cnt_r <= clr_cnt_r + IDX_W'(1);
      if (clr_cnt_r == IDX_LAST) begin
        clearing_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (vld_we) begin
      vld_mem[vld_waddr] <= vld_wdata;
    end
    rd_vld <= vld_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (key_wr_en) begin
      key_mem[wr_addr] <= wr_key;
    end
    rd_key <= key_mem[rd_addr];
  end

endmodule

// File: design/linear_probe_hash_set_unit.sv
// Top level of the linear probing hash set: request sequencer, probe loop and output register.
// Each request runs the hash modulo, then probes slots in turn, then goes to the output register.
// A refused add skips the modulo and probe and goes straight from idle to the output state.
// Requests are taken one at a time: a new one is taken only once the last has left the output state.
// After reset the valid memory is swept, one slot a cycle, over all TABLE_DEPTH slots; no request
// is taken during the sweep, while configuration writes are taken as ever.
module linear_probe_hash_set_unit #(
  parameter int TABLE_DEPTH = 256,
  parameter int KEY_WIDTH   = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  lphs_pkg::in_item_t           in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output lphs_pkg::out_item_t          out_data,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lphs_pkg::PADDR_W-1:0] paddr,
  input  logic [lphs_pkg::PDATA_W-1:0] pwdata,
  output logic [lphs_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);
  import lphs_pkg::*;

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int CW    = (IDX_W + 1 > CAP_W) ? IDX_W + 1 : CAP_W;
  localparam int FW    = ((CNT_W > CAP_W) ? CNT_W : CAP_W) + 1;

  logic [CAP_W-1:0]     eff_cap;
  logic                 mod_start;
  logic                 mod_done;
  logic [CAP_W-1:0]     mod_rem;
  logic                 mem_ready;
  logic                 rd_vld;
  logic [KEY_WIDTH-1:0] rd_key;
  logic                 vld_wr_en;
  logic                 wr_vld;
  logic                 key_wr_en;

  state_t               state_r, state_nxt;
  logic [1:0]           op_r;
  logic [KEY_WIDTH-1:0] key_r;
  logic [IDX_W-1:0]     issue_idx_r;
  logic [IDX_W-1:0]     eval_idx_r;
  logic                 data_vld_r;
  logic [CAP_W-1:0]     n_r;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  out_item_t            res_r, res_nxt;
  out_item_t            out_r;
  logic                 out_valid_r;

  logic                 in_xfer;
  logic                 out_free;
  logic                 is_full;
  logic                 refuse;
  logic                 last_probe;
  logic                 term;
  logic [CW-1:0]        idx_inc;
  logic [IDX_W-1:0]     issue_idx_nxt;

  lphs_cfg_regs #(.TABLE_DEPTH(TABLE_DEPTH)) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .eff_cap (eff_cap)
  );

  lphs_mod_unit u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (mod_start),
    .dividend  (in_data.key_hash),
    .divisor   (eff_cap),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  lphs_slot_mem #(.TABLE_DEPTH(TABLE_DEPTH), .KEY_WIDTH(KEY_WIDTH)) u_mem (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_addr   (issue_idx_r),
    .rd_vld    (rd_vld),
    .rd_key    (rd_key),
    .wr_addr   (eval_idx_r),
    .vld_wr_en (vld_wr_en),
    .wr_vld    (wr_vld),
    .key_wr_en (key_wr_en),
    .wr_key    (key_r),
    .ready     (mem_ready)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign is_full   = (FW'(cnt_r) + FW'(2)) > FW'(eff_cap);
  assign refuse    = (in_data.op == OP_ADD) && is_full;
  assign mod_start = in_xfer && !refuse;

  assign last_probe    = ((n_r + CAP_W'(1)) == eff_cap);
  assign idx_inc       = CW'(issue_idx_r) + CW'(1);
  assign issue_idx_nxt = (idx_inc == CW'(eff_cap)) ? '0 : IDX_W'(idx_inc);

  // The slot memory is written only when a probe ends; the next request reads it after the
  // modulo has run, so a read never overlaps a pending write to the same slot.
  always_comb begin
    term      = 1'b0;
    vld_wr_en = 1'b0;
    wr_vld    = 1'b0;
    key_wr_en = 1'b0;
    cnt_nxt   = cnt_r;
    res_nxt   = res_r;
    if (state_r == ST_IDLE && in_xfer && refuse) begin
      res_nxt = '{status: STAT_FULL, found: 1'b0, slot: '0, removed_key: '0,
                  entry_total: CAP_W'(cnt_r)};
    end else if (state_r == ST_PROBE && data_vld_r) begin
      if (op_r == OP_ADD) begin
        if (!rd_vld) begin
          term      = 1'b1;
          vld_wr_en = 1'b1;
          wr_vld    = 1'b1;
          key_wr_en = 1'b1;
          cnt_nxt   = cnt_r + CNT_W'(1);
          res_nxt   = '{status: STAT_OK, found: 1'b0, slot: SLOT_W'(eval_idx_r),
                        removed_key: '0, entry_total: CAP_W'(cnt_nxt)};
        end else if (rd_key == key_r) begin
          term      = 1'b1;
          key_wr_en = 1'b1;
          res_nxt   = '{status: STAT_OK, found: 1'b1, slot: SLOT_W'(eval_idx_r),
                        removed_key: '0, entry_total: CAP_W'(cnt_r)};
        end
      end else if (rd_vld && (rd_key == key_r)) begin
        term    = 1'b1;
        res_nxt = '{status: STAT_OK, found: 1'b1, slot: SLOT_W'(eval_idx_r),
                    removed_key: '0, entry_total: CAP_W'(cnt_r)};
        if (op_r == OP_REMOVE) begin
          vld_wr_en = 1'b1;
          wr_vld    = 1'b0;
          if (cnt_r != '0) begin
            cnt_nxt = cnt_r - CNT_W'(1);
          end
          res_nxt.removed_key = IN_KEY_W'(rd_key);
          res_nxt.entry_total = CAP_W'(cnt_nxt);
        end
      end else if (last_probe) begin
        term    = 1'b1;
        res_nxt = '{status: STAT_NOT_FOUND, found: 1'b0, slot: '0, removed_key: '0,
                    entry_total: CAP_W'(cnt_r)};
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (mem_ready) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_xfer) state_nxt = refuse ? ST_OUT : ST_HASH;
      end
      ST_HASH: begin
        if (mod_done) state_nxt = ST_PROBE;
      end
      ST_PROBE: begin
        if (term) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      data_vld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (state_r == ST_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == ST_HASH) begin
        data_vld_r <= 1'b0;
      end else if (state_r == ST_PROBE) begin
        data_vld_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (in_xfer) begin
      op_r  <= in_data.op;
      key_r <= KEY_WIDTH'(in_data.key);
    end
    if (state_r == ST_HASH && mod_done) begin
      issue_idx_r <= IDX_W'(mod_rem);
      n_r         <= '0;
    end else if (state_r == ST_PROBE) begin
      issue_idx_r <= issue_idx_nxt;
      eval_idx_r  <= issue_idx_r;
      if (data_vld_r) begin
        n_r <= n_r + CAP_W'(1);
      end
    end
    if (state_r == ST_OUT && out_free) begin
      out_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_no_request_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    !mem_ready |-> in_stall)
    else $error("request taken during the valid sweep");

  a_write_only_at_probe_end: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_wr_en || key_wr_en) |-> (state_r == ST_PROBE && data_vld_r && term))
    else $error("slot memory written outside the end of a probe");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    FW'(cnt_r) <= FW'(TABLE_DEPTH))
    else $error("entry count above the table depth");

  a_refused_add_direct: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && in_xfer && refuse) |=> (state_r == ST_OUT && res_r.status == STAT_FULL))
    else $error("refused add did not go straight to the output");

  a_probe_within_ring: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PROBE) |-> (n_r < eff_cap))
    else $error("probe ran past the ring");

endmodule
